// File: rtl/tqls_pkg.sv
`timescale 1ns / 1ps

package tqls_pkg;

    // table geometry
    localparam int ANGLE_BINS    = 16;
    localparam int DIST_BINS     = 8;
    localparam int ACCEL_ACTIONS = 8;
    localparam int STEER_ACTIONS = 8;
    localparam int TABLE_SIZE    = ANGLE_BINS * DIST_BINS * ACCEL_ACTIONS * STEER_ACTIONS;

    localparam int ANG_W   = $clog2(ANGLE_BINS);
    localparam int DIST_W  = $clog2(DIST_BINS);
    localparam int ACC_W   = $clog2(ACCEL_ACTIONS);
    localparam int STEER_W = $clog2(STEER_ACTIONS);
    localparam int ADDR_W  = $clog2(TABLE_SIZE);

    localparam int Q_W     = 32;
    localparam int COEF_W  = 16;
    localparam int DIFF_W  = 34;
    localparam int MRES_W  = 35;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT_FACTOR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE_THRESHOLD = 2'd2;

    localparam logic [COEF_W-1:0] LEARNING_RATE_RST     = 16'd6554;
    localparam logic [COEF_W-1:0] DISCOUNT_FACTOR_RST   = 16'd58982;
    localparam logic [COEF_W-1:0] EXPLORE_THRESHOLD_RST = 16'd6554;

    typedef struct packed {
        logic [3:0]        angle_bin;
        logic [2:0]        dist_bin;
        logic signed [31:0] reward_value;
        logic [15:0]       explore_draw;
        logic [2:0]        random_accel;
        logic [2:0]        random_steer;
        logic [2:0]        scan_start_accel;
        logic [2:0]        scan_start_steer;
    } in_word_t;

    typedef struct packed {
        logic [2:0] accel_action;
        logic [2:0] steer_action;
        logic       explored;
    } out_word_t;

    // request to the shared multiplier
    typedef struct packed {
        logic                     start;
        logic [COEF_W-1:0]        coef;
        logic signed [DIFF_W-1:0] operand;
    } mul_req_t;

    // reduce a narrow index modulo a small count by repeated subtraction
    function automatic logic [3:0] reduce_index(input logic [3:0] v, input logic [6:0] n);
        logic [6:0] r;
        r = {3'b000, v};
        for (int i = 0; i < 8; i++) begin
            if (r >= n) begin
                r = r - n;
            end
        end
        return r[3:0];
    endfunction

    function automatic logic [ADDR_W-1:0] entry_addr(input logic [ANG_W-1:0]   a,
                                                     input logic [DIST_W-1:0]  d,
                                                     input logic [ACC_W-1:0]   acc,
                                                     input logic [STEER_W-1:0] st);
        return ((ADDR_W'(a) * ADDR_W'(DIST_BINS) + ADDR_W'(d)) * ADDR_W'(ACCEL_ACTIONS)
                + ADDR_W'(acc)) * ADDR_W'(STEER_ACTIONS) + ADDR_W'(st);
    endfunction

endpackage

// File: rtl/tqls_ram.sv
`timescale 1ns / 1ps

module tqls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/tqls_mul.sv
`timescale 1ns / 1ps

module tqls_mul (
    input  logic                             aclk,
    input  tqls_pkg::mul_req_t               req,
    output logic signed [tqls_pkg::MRES_W-1:0] result
);
    import tqls_pkg::*;

    localparam int PROD_W = COEF_W + 1 + DIFF_W;

    logic signed [PROD_W-1:0] prod;
    logic signed [MRES_W-1:0] result_reg;

    // unsigned Q0.16 coefficient times signed operand, floored back by 2^16
    always_comb begin
        prod = $signed({1'b0, req.coef}) * req.operand;
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            result_reg <= prod[PROD_W-1:16];
        end
    end

    assign result = result_reg;

endmodule

// File: rtl/tabular_q_learning_step_unit.sv
`timescale 1ns / 1ps

// Tabular Q-learning step with epsilon-greedy choice. Each accepted word names a state, the
// reward of the last action and random draws; the block scans that state's 64 Q entries for
// the best action, updates the previous state-action entry, and returns one result word.
// s_ready stays low from acceptance of a word until its result is written to the output
// register. A result still waiting in the output register holds the block in its final
// state, so back-pressure on m_ready delays the return to idle. Each step is the row scan,
// one entry per cycle through the single read port of the table memory, followed, on every
// step but the first, by the update's read, two passes through the shared multiplier and
// the write. After reset the table is cleared one entry per cycle, all 8192 entries, with
// s_ready low; configuration writes are taken at all times. A finished result waits in the
// output register while the next word is accepted.
module tabular_q_learning_step_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  tqls_pkg::in_word_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output tqls_pkg::out_word_t               m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tqls_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tqls_pkg::COEF_W-1:0]       cfg_data
);
    import tqls_pkg::*;

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_CLEAR    = 4'd0;
    localparam logic [ST_W-1:0] ST_IDLE     = 4'd1;
    localparam logic [ST_W-1:0] ST_SEED     = 4'd2;
    localparam logic [ST_W-1:0] ST_SCAN     = 4'd3;
    localparam logic [ST_W-1:0] ST_DRAIN    = 4'd4;
    localparam logic [ST_W-1:0] ST_OLD_RD   = 4'd5;
    localparam logic [ST_W-1:0] ST_OLD_WAIT = 4'd6;
    localparam logic [ST_W-1:0] ST_MUL_T    = 4'd7;
    localparam logic [ST_W-1:0] ST_DIFF     = 4'd8;
    localparam logic [ST_W-1:0] ST_MUL_D    = 4'd9;
    localparam logic [ST_W-1:0] ST_WRITE    = 4'd10;
    localparam logic [ST_W-1:0] ST_DONE     = 4'd11;

    localparam logic signed [MRES_W-1:0] SAT_MAX = 35'sh0_7FFF_FFFF;
    localparam logic signed [MRES_W-1:0] SAT_MIN = 35'sh7_8000_0000;

    logic [ST_W-1:0]    state_reg, state_next;
    logic [ADDR_W-1:0]  clr_cnt_reg, clr_cnt_next;

    logic [ANG_W-1:0]   ang_reg, ang_next;
    logic [DIST_W-1:0]  dist_reg, dist_next;
    logic signed [Q_W-1:0] reward_reg, reward_next;
    logic [COEF_W-1:0]  draw_reg, draw_next;
    logic [ACC_W-1:0]   racc_reg, racc_next;
    logic [STEER_W-1:0] rst_reg, rst_next;
    logic [ACC_W-1:0]   seed_acc_reg, seed_acc_next;
    logic [STEER_W-1:0] seed_st_reg, seed_st_next;

    logic [ACC_W-1:0]   acc_cnt_reg, acc_cnt_next;
    logic [STEER_W-1:0] st_cnt_reg, st_cnt_next;

    logic               tag_vld_reg, tag_vld_next;
    logic               tag_seed_reg, tag_seed_next;
    logic [ACC_W-1:0]   tag_acc_reg, tag_acc_next;
    logic [STEER_W-1:0] tag_st_reg, tag_st_next;

    logic signed [Q_W-1:0] best_reg, best_next;
    logic [ACC_W-1:0]   best_acc_reg, best_acc_next;
    logic [STEER_W-1:0] best_st_reg, best_st_next;

    logic               have_prev_reg, have_prev_next;
    logic [ANG_W-1:0]   prev_ang_reg, prev_ang_next;
    logic [DIST_W-1:0]  prev_dist_reg, prev_dist_next;
    logic [ACC_W-1:0]   prev_acc_reg, prev_acc_next;
    logic [STEER_W-1:0] prev_st_reg, prev_st_next;

    logic signed [Q_W-1:0]    old_reg, old_next;
    logic signed [DIFF_W-1:0] diff_reg, diff_next;

    logic [COEF_W-1:0]  lr_reg, lr_next;
    logic [COEF_W-1:0]  df_reg, df_next;
    logic [COEF_W-1:0]  thr_reg, thr_next;

    logic               m_valid_reg, m_valid_next;
    out_word_t          m_data_reg, m_data_next;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [Q_W-1:0]     ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [Q_W-1:0]     ram_rdata;
    logic signed [Q_W-1:0] rd_q;

    mul_req_t                 mul_req;
    logic signed [MRES_W-1:0] mul_res;

    logic signed [MRES_W-1:0] upd_sum;
    logic signed [Q_W-1:0]    upd_sat;
    logic                     explore;
    logic [ADDR_W-1:0]        prev_addr;

    tqls_ram #(
        .WIDTH (Q_W),
        .DEPTH (TABLE_SIZE)
    ) u_qtab (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tqls_mul u_mul (
        .aclk   (aclk),
        .req    (mul_req),
        .result (mul_res)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign rd_q      = $signed(ram_rdata);
    assign prev_addr = entry_addr(prev_ang_reg, prev_dist_reg, prev_acc_reg, prev_st_reg);
    assign explore   = (draw_reg < thr_reg);

    // old + floor(lr * diff), saturated to 32 bits
    always_comb begin
        upd_sum = MRES_W'(old_reg) + mul_res;
        if (upd_sum > SAT_MAX) begin
            upd_sat = SAT_MAX[Q_W-1:0];
        end else if (upd_sum < SAT_MIN) begin
            upd_sat = SAT_MIN[Q_W-1:0];
        end else begin
            upd_sat = upd_sum[Q_W-1:0];
        end
    end

    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        ang_next       = ang_reg;
        dist_next      = dist_reg;
        reward_next    = reward_reg;
        draw_next      = draw_reg;
        racc_next      = racc_reg;
        rst_next       = rst_reg;
        seed_acc_next  = seed_acc_reg;
        seed_st_next   = seed_st_reg;
        acc_cnt_next   = acc_cnt_reg;
        st_cnt_next    = st_cnt_reg;
        tag_vld_next   = 1'b0;
        tag_seed_next  = 1'b0;
        tag_acc_next   = tag_acc_reg;
        tag_st_next    = tag_st_reg;
        best_next      = best_reg;
        best_acc_next  = best_acc_reg;
        best_st_next   = best_st_reg;
        have_prev_next = have_prev_reg;
        prev_ang_next  = prev_ang_reg;
        prev_dist_next = prev_dist_reg;
        prev_acc_next  = prev_acc_reg;
        prev_st_next   = prev_st_reg;
        old_next       = old_reg;
        diff_next      = diff_reg;
        lr_next        = lr_reg;
        df_next        = df_reg;
        thr_next       = thr_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        ram_we    = 1'b0;
        ram_waddr = clr_cnt_reg;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = prev_addr;

        mul_req.start   = 1'b0;
        mul_req.coef    = df_reg;
        mul_req.operand = DIFF_W'(best_reg);

        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_LEARNING_RATE:     lr_next  = cfg_data;
                CFG_DISCOUNT_FACTOR:   df_next  = cfg_data;
                CFG_EXPLORE_THRESHOLD: thr_next = cfg_data;
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // read data returns in the cycle after its address; the seed word opens the scan
        if (tag_vld_reg) begin
            if (tag_seed_reg) begin
                best_next     = rd_q;
                best_acc_next = tag_acc_reg;
                best_st_next  = tag_st_reg;
            end else if (rd_q > best_reg) begin
                best_next     = rd_q;
                best_acc_next = tag_acc_reg;
                best_st_next  = tag_st_reg;
            end
        end

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we = 1'b1;
                if (clr_cnt_reg == ADDR_W'(TABLE_SIZE - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    ang_next      = ANG_W'(reduce_index(s_data.angle_bin, 7'(ANGLE_BINS)));
                    dist_next     = DIST_W'(reduce_index(4'(s_data.dist_bin), 7'(DIST_BINS)));
                    reward_next   = s_data.reward_value;
                    draw_next     = s_data.explore_draw;
                    racc_next     = ACC_W'(reduce_index(4'(s_data.random_accel),
                                                        7'(ACCEL_ACTIONS)));
                    rst_next      = STEER_W'(reduce_index(4'(s_data.random_steer),
                                                          7'(STEER_ACTIONS)));
                    seed_acc_next = ACC_W'(reduce_index(4'(s_data.scan_start_accel),
                                                        7'(ACCEL_ACTIONS)));
                    seed_st_next  = STEER_W'(reduce_index(4'(s_data.scan_start_steer),
                                                          7'(STEER_ACTIONS)));
                    state_next    = ST_SEED;
                end
            end
            ST_SEED: begin
                ram_re        = 1'b1;
                ram_raddr     = entry_addr(ang_reg, dist_reg, seed_acc_reg, seed_st_reg);
                tag_vld_next  = 1'b1;
                tag_seed_next = 1'b1;
                tag_acc_next  = seed_acc_reg;
                tag_st_next   = seed_st_reg;
                acc_cnt_next  = '0;
                st_cnt_next   = '0;
                state_next    = ST_SCAN;
            end
            ST_SCAN: begin
                ram_re       = 1'b1;
                ram_raddr    = entry_addr(ang_reg, dist_reg, acc_cnt_reg, st_cnt_reg);
                tag_vld_next = 1'b1;
                tag_acc_next = acc_cnt_reg;
                tag_st_next  = st_cnt_reg;
                if (st_cnt_reg == STEER_W'(STEER_ACTIONS - 1)) begin
                    st_cnt_next = '0;
                    if (acc_cnt_reg == ACC_W'(ACCEL_ACTIONS - 1)) begin
                        state_next = ST_DRAIN;
                    end else begin
                        acc_cnt_next = acc_cnt_reg + 1'b1;
                    end
                end else begin
                    st_cnt_next = st_cnt_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = have_prev_reg ? ST_OLD_RD : ST_DONE;
            end
            ST_OLD_RD: begin
                ram_re     = 1'b1;
                state_next = ST_OLD_WAIT;
            end
            ST_OLD_WAIT: begin
                old_next   = rd_q;
                state_next = ST_MUL_T;
            end
            ST_MUL_T: begin
                mul_req.start = 1'b1;
                state_next    = ST_DIFF;
            end
            ST_DIFF: begin
                diff_next  = DIFF_W'(reward_reg) + DIFF_W'(mul_res) - DIFF_W'(old_reg);
                state_next = ST_MUL_D;
            end
            ST_MUL_D: begin
                mul_req.start   = 1'b1;
                mul_req.coef    = lr_reg;
                mul_req.operand = diff_reg;
                state_next      = ST_WRITE;
            end
            ST_WRITE: begin
                ram_we     = 1'b1;
                ram_waddr  = prev_addr;
                ram_wdata  = upd_sat;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    have_prev_next = 1'b1;
                    prev_ang_next  = ang_reg;
                    prev_dist_next = dist_reg;
                    prev_acc_next  = explore ? racc_reg : best_acc_reg;
                    prev_st_next   = explore ? rst_reg : best_st_reg;
                    m_data_next.accel_action = 3'(explore ? racc_reg : best_acc_reg);
                    m_data_next.steer_action = 3'(explore ? rst_reg : best_st_reg);
                    m_data_next.explored     = explore;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            tag_vld_reg   <= 1'b0;
            tag_seed_reg  <= 1'b0;
            have_prev_reg <= 1'b0;
            prev_ang_reg  <= '0;
            prev_dist_reg <= '0;
            prev_acc_reg  <= '0;
            prev_st_reg   <= '0;
            lr_reg        <= LEARNING_RATE_RST;
            df_reg        <= DISCOUNT_FACTOR_RST;
            thr_reg       <= EXPLORE_THRESHOLD_RST;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            tag_vld_reg   <= tag_vld_next;
            tag_seed_reg  <= tag_seed_next;
            have_prev_reg <= have_prev_next;
            prev_ang_reg  <= prev_ang_next;
            prev_dist_reg <= prev_dist_next;
            prev_acc_reg  <= prev_acc_next;
            prev_st_reg   <= prev_st_next;
            lr_reg        <= lr_next;
            df_reg        <= df_next;
            thr_reg       <= thr_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ang_reg      <= ang_next;
        dist_reg     <= dist_next;
        reward_reg   <= reward_next;
        draw_reg     <= draw_next;
        racc_reg     <= racc_next;
        rst_reg      <= rst_next;
        seed_acc_reg <= seed_acc_next;
        seed_st_reg  <= seed_st_next;
        acc_cnt_reg  <= acc_cnt_next;
        st_cnt_reg   <= st_cnt_next;
        tag_acc_reg  <= tag_acc_next;
        tag_st_reg   <= tag_st_next;
        best_reg     <= best_next;
        best_acc_reg <= best_acc_next;
        best_st_reg  <= best_st_next;
        old_reg      <= old_next;
        diff_reg     <= diff_next;
        m_data_reg   <= m_data_next;
    end

    // table writes come only from the clearing sweep or an update of a known previous entry
    a_write_source: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_CLEAR) || (state_reg == ST_WRITE && have_prev_reg))
        else $error("table write outside clear or update");

    // a result word appears only on leaving the done state
    a_result_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside done state");

    // an accepted word always starts with the seed read
    a_accept_seed: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_SEED)
        else $error("accepted word did not start the scan");

    // returning scan data is only expected while the row is being scanned or drained
    a_tag_window: assert property (@(posedge aclk) disable iff (!aresetn)
        tag_vld_reg |-> (state_reg == ST_SCAN) || (state_reg == ST_DRAIN))
        else $error("scan data outside scan window");

endmodule
